### hw/rtl/led_strip_pattern_pixel_macros.svh
// Assertion macros used by the pattern pixel top-level RTL.
`ifndef LED_STRIP_PATTERN_PIXEL_MACROS_SVH
`define LED_STRIP_PATTERN_PIXEL_MACROS_SVH

// Same-cycle implication.
`define LSPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LSPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lspp_pkg.sv
// Types and constants for the LED strip pattern pixel generator.
package lspp_pkg;

	localparam int MAX_LEDS = 1024;

	localparam logic [1:0] MODE_SOLID   = 2'd0;
	localparam logic [1:0] MODE_RAINBOW = 2'd1;
	localparam logic [1:0] MODE_SQUARE  = 2'd2;

	localparam logic [1:0] REG_MODE       = 2'd0;
	localparam logic [1:0] REG_SOLID      = 2'd1;
	localparam logic [1:0] REG_SATURATION = 2'd2;
	localparam logic [1:0] REG_LIGHTNESS  = 2'd3;

	localparam logic [1:0] RESET_MODE       = MODE_RAINBOW;
	localparam logic [31:0] RESET_SOLID     = 32'd0;
	localparam logic [7:0] RESET_SATURATION = 8'd255;
	localparam logic [7:0] RESET_LIGHTNESS  = 8'd128;

	localparam logic [7:0] HUE_THIRD      = 8'd85;
	localparam logic [7:0] HUE_TWO_THIRDS = 8'd170;
	localparam logic [7:0] HUE_MAX        = 8'd255;
	localparam logic [7:0] HALF_LIGHT     = 8'd128;
	localparam logic [8:0] CHAN_FULL      = 9'd256;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] solid;
		logic [7:0]  sat;
		logic [7:0]  light;
	} cfg_t;

endpackage

### hw/rtl/lspp_cfg_regs.sv
// Configuration register file for the pattern pixel generator.
module lspp_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output lspp_pkg::cfg_t    cfg
);

	lspp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= lspp_pkg::RESET_MODE;
			cfg_q.solid <= lspp_pkg::RESET_SOLID;
			cfg_q.sat   <= lspp_pkg::RESET_SATURATION;
			cfg_q.light <= lspp_pkg::RESET_LIGHTNESS;
		end else if (cfg_wen) begin
			case (cfg_index)
				lspp_pkg::REG_MODE:       cfg_q.mode  <= cfg_data[1:0];
				lspp_pkg::REG_SOLID:      cfg_q.solid <= cfg_data;
				lspp_pkg::REG_SATURATION: cfg_q.sat   <= cfg_data[7:0];
				lspp_pkg::REG_LIGHTNESS:  cfg_q.light <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/lspp_chan.sv
// One HSL colour channel: hue interpolation multiply stage and saturating add.
module lspp_chan (
	input  logic       clk,
	input  logic       en_s3,
	input  logic [7:0] x_s2,
	input  logic [7:0] p_s2,
	input  logic [8:0] q_s2,
	input  logic [8:0] diff_s2,
	output logic [7:0] chan
);

	logic [6:0]  factor;
	logic        sel_q;
	logic [7:0]  mirror;
	logic [15:0] prod_s3;
	logic [7:0]  p_s3;
	logic [8:0]  q_s3;
	logic        sel_q_s3;
	logic [8:0]  sum;
	logic [8:0]  val;

	always_comb begin
		mirror = lspp_pkg::HUE_MAX - x_s2;
		sel_q  = 1'b0;
		if (x_s2 < lspp_pkg::HUE_THIRD) begin
			factor = x_s2[6:0];
		end else if (x_s2 < lspp_pkg::HUE_TWO_THIRDS) begin
			factor = 7'd0;
			sel_q  = 1'b1;
		end else begin
			factor = mirror[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3  <= diff_s2 * {2'b00, factor};
			p_s3     <= p_s2;
			q_s3     <= q_s2;
			sel_q_s3 <= sel_q;
		end
	end

	always_comb begin
		sum  = {1'b0, p_s3} + {1'b0, prod_s3[15:8]};
		val  = sel_q_s3 ? q_s3 : sum;
		chan = (val >= lspp_pkg::CHAN_FULL) ? 8'hFF : val[7:0];
	end

endmodule

### hw/rtl/led_strip_pattern_pixel.sv
// LED strip pattern pixel generator, top level.
// Accepts one item per cycle unless a stalled output has filled the pipeline.
// Four pipeline stages: hue/q terms and index square, channel operands,
// interpolation multiply, saturate and pack into the output register.
// Stages with a bubble keep filling while the output is stalled.
// Asynchronous active-low reset empties the pipeline and loads register defaults.
module led_strip_pattern_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] frame_time,
	input  logic [9:0]  led_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_word,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "led_strip_pattern_pixel_macros.svh"

	lspp_pkg::cfg_t cfg;

	lspp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: hue, index square, q and p terms
	logic [31:0] hue_sum;
	logic        low_light;
	logic [8:0]  q_mul_b;
	logic [16:0] q_prod;
	logic [8:0]  q_val;
	logic [9:0]  p_wide;

	always_comb begin
		hue_sum   = frame_time + {25'd0, led_index[9:3]};
		low_light = cfg.light < lspp_pkg::HALF_LIGHT;
		q_mul_b   = low_light ? (lspp_pkg::CHAN_FULL + {1'b0, cfg.sat}) : {1'b0, cfg.sat};
		q_prod    = cfg.light * q_mul_b;
		if (low_light) begin
			q_val = q_prod[16:8];
		end else begin
			q_val = {1'b0, cfg.light} + {1'b0, cfg.sat} - {1'b0, q_prod[15:8]};
		end
		p_wide = {1'b0, cfg.light, 1'b0} - {1'b0, q_val};
	end

	logic [7:0]  hue_s1;
	logic [19:0] sq_s1;
	logic [23:0] t_s1;
	logic        in_range_s1;
	logic [8:0]  q_s1;
	logic [7:0]  p_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			hue_s1      <= hue_sum[12:5];
			sq_s1       <= led_index * led_index;
			t_s1        <= frame_time[23:0];
			in_range_s1 <= {7'd0, led_index} < 17'(lspp_pkg::MAX_LEDS);
			q_s1        <= q_val;
			p_s1        <= p_wide[7:0];
		end
	end

	// stage 2: channel hue offsets, difference, square word
	logic [7:0]  xr_s2, xg_s2, xb_s2;
	logic [7:0]  p_s2;
	logic [8:0]  q_s2;
	logic [8:0]  diff_s2;
	logic [23:0] sqw_s2;
	logic        in_range_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			xr_s2       <= hue_s1 + lspp_pkg::HUE_THIRD;
			xg_s2       <= hue_s1;
			xb_s2       <= hue_s1 - lspp_pkg::HUE_THIRD;
			p_s2        <= p_s1;
			q_s2        <= q_s1;
			diff_s2     <= q_s1 - {1'b0, p_s1};
			sqw_s2      <= t_s1 + {4'd0, sq_s1};
			in_range_s2 <= in_range_s1;
		end
	end

	// stage 3: interpolation multiply in the channel units
	logic [7:0] red, green, blue;

	lspp_chan u_red (
		.clk     (clk),
		.en_s3   (rdy_s3),
		.x_s2    (xr_s2),
		.p_s2    (p_s2),
		.q_s2    (q_s2),
		.diff_s2 (diff_s2),
		.chan    (red)
	);

	lspp_chan u_green (
		.clk     (clk),
		.en_s3   (rdy_s3),
		.x_s2    (xg_s2),
		.p_s2    (p_s2),
		.q_s2    (q_s2),
		.diff_s2 (diff_s2),
		.chan    (green)
	);

	lspp_chan u_blue (
		.clk     (clk),
		.en_s3   (rdy_s3),
		.x_s2    (xb_s2),
		.p_s2    (p_s2),
		.q_s2    (q_s2),
		.diff_s2 (diff_s2),
		.chan    (blue)
	);

	logic [23:0] sqw_s3;
	logic        in_range_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sqw_s3      <= sqw_s2;
			in_range_s3 <= in_range_s2;
		end
	end

	// stage 4: pattern select into the output register
	logic [31:0] word;
	logic [31:0] word_s4;

	always_comb begin
		case (cfg.mode)
			lspp_pkg::MODE_SOLID:   word = cfg.solid;
			lspp_pkg::MODE_RAINBOW: word = {green, red, blue, 8'd0};
			lspp_pkg::MODE_SQUARE:  word = {8'd0, sqw_s3};
			default:                word = 32'd0;
		endcase
		if (!in_range_s3) word = 32'd0;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) word_s4 <= word;
	end

	assign out_valid  = v_s4;
	assign pixel_word = word_s4;

	`LSPP_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && out_stall, "input stalled with a bubble in the pipe")
	`LSPP_ASSERT_NEXT(a_s3_to_out, clk, arst_n, v_s3 && rdy_s4, out_valid,
		"item lost between stage 3 and output")
	`LSPP_ASSERT_NEXT(a_range_zero, clk, arst_n, v_s3 && rdy_s4 && !in_range_s3,
		pixel_word == 32'd0, "out-of-strip LED gave nonzero word")

endmodule

### tb/sv/led_strip_pattern_pixel_tb.sv
// Self-checking testbench for the LED strip pattern pixel generator.
module led_strip_pattern_pixel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] frame_time = '0;
	logic [9:0]  led_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] pixel_word;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	lspp_pkg::cfg_t shadow_cfg;
	logic [31:0] expected_words[$];
	logic [31:0] want_word;
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;
	int          stuck_cycles = 0;

	led_strip_pattern_pixel dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_time (frame_time),
		.led_index  (led_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_word (pixel_word),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] channel_level(int p, int q, logic [7:0] x);
		int xi;
		int v;
		xi = x;
		if (x < lspp_pkg::HUE_THIRD) begin
			v = p + (((q - p) * xi) >>> 8);
		end else if (x < lspp_pkg::HUE_TWO_THIRDS) begin
			v = q;
		end else begin
			v = p + (((q - p) * (int'(lspp_pkg::HUE_MAX) - xi)) >>> 8);
		end
		// 256 and above saturate instead of wrapping
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [31:0] hsl_to_grb(logic [7:0] hue, logic [7:0] sat,
		logic [7:0] light);
		int s;
		int l;
		int q;
		int p;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		s = sat;
		l = light;
		if (sat == 8'd0) return {light, light, light, 8'h00};
		if (l < int'(lspp_pkg::HALF_LIGHT)) begin
			q = (l * (256 + s)) >>> 8;
		end else begin
			q = l + s - ((l * s) >>> 8);
		end
		p = 2 * l - q;
		r = channel_level(p, q, hue + lspp_pkg::HUE_THIRD);
		g = channel_level(p, q, hue);
		b = channel_level(p, q, hue - lspp_pkg::HUE_THIRD);
		return {g, r, b, 8'h00};
	endfunction

	function automatic logic [31:0] pixel_for(logic [31:0] t, logic [9:0] idx);
		logic [31:0] hue_sum;
		logic [31:0] square_sum;
		case (shadow_cfg.mode)
			lspp_pkg::MODE_SOLID: return shadow_cfg.solid;
			lspp_pkg::MODE_RAINBOW: begin
				hue_sum = t + 32'(idx >> 3);
				return hsl_to_grb(hue_sum[12:5], shadow_cfg.sat, shadow_cfg.light);
			end
			lspp_pkg::MODE_SQUARE: begin
				square_sum = t + 32'(idx) * 32'(idx);
				return {8'h00, square_sum[23:0]};
			end
			default: return '0;
		endcase
	endfunction

	function automatic logic [31:0] random_time();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'hFFFF_FFFF - $urandom_range(63);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [9:0] random_index();
		case ($urandom_range(7))
			0: return 10'd0;
			1: return 10'd1023;
			default: return 10'($urandom_range(1023));
		endcase
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			lspp_pkg::REG_MODE:       shadow_cfg.mode = data[1:0];
			lspp_pkg::REG_SOLID:      shadow_cfg.solid = data;
			lspp_pkg::REG_SATURATION: shadow_cfg.sat = data[7:0];
			lspp_pkg::REG_LIGHTNESS:  shadow_cfg.light = data[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [31:0] t, logic [9:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_time <= t;
		led_index <= idx;
		do @(posedge clk); while (in_stall);
		expected_words.push_back(pixel_for(t, idx));
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected item, pixel_word %08h", $time, pixel_word);
				error_count++;
			end else begin
				want_word = expected_words.pop_front();
				if (pixel_word !== want_word) begin
					$display("%0t: pixel_word mismatch: expected %08h, actual %08h",
						$time, want_word, pixel_word);
					error_count++;
				end
			end
		end
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, STUCK_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic test_reset_rainbow();
		send_pixel(32'd0, 10'd0);
		send_pixel(32'hFFFF_FFFF, 10'd1023);
		send_pixel(32'(8'd84) << 5, 10'd0);
		send_pixel(32'(lspp_pkg::HUE_THIRD) << 5, 10'd0);
		send_pixel(32'(8'd169) << 5, 10'd0);
		send_pixel(32'(lspp_pkg::HUE_TWO_THIRDS) << 5, 10'd0);
		send_pixel(32'(lspp_pkg::HUE_MAX) << 5, 10'd0);
		send_pixel(32'd31, 10'd8);
		drain_pixels();
	endtask

	task automatic test_channel_overflow();
		write_reg(lspp_pkg::REG_LIGHTNESS, 32'd255);
		write_reg(lspp_pkg::REG_SATURATION, 32'd255);
		send_pixel(32'd100 << 5, 10'd0);
		send_pixel(32'd0, 10'd0);
		drain_pixels();
	endtask

	task automatic test_grey();
		// upper bits of a wide write are dropped
		write_reg(lspp_pkg::REG_SATURATION, 32'hABCD_EF00);
		send_pixel($urandom(), random_index());
		drain_pixels();
		write_reg(lspp_pkg::REG_LIGHTNESS, 32'd0);
		write_reg(lspp_pkg::REG_SATURATION, 32'd255);
		send_pixel($urandom(), random_index());
		drain_pixels();
	endtask

	task automatic test_solid();
		write_reg(lspp_pkg::REG_MODE, 32'(lspp_pkg::MODE_SOLID));
		write_reg(lspp_pkg::REG_SOLID, 32'hFFFF_FFFF);
		send_pixel($urandom(), random_index());
		drain_pixels();
		write_reg(lspp_pkg::REG_SOLID, 32'd0);
		send_pixel($urandom(), random_index());
		drain_pixels();
	endtask

	task automatic test_square();
		write_reg(lspp_pkg::REG_MODE, 32'(lspp_pkg::MODE_SQUARE));
		send_pixel(32'hFFFF_FFFF, 10'd1023);
		send_pixel(32'd0, 10'd0);
		send_pixel(32'h00FF_FFFF, 10'd1);
		drain_pixels();
	endtask

	task automatic test_unused_mode();
		write_reg(lspp_pkg::REG_MODE, 32'hFFFF_FFFF);
		send_pixel($urandom(), random_index());
		send_pixel($urandom(), random_index());
		drain_pixels();
	endtask

	task automatic test_output_backpressure();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		write_reg(lspp_pkg::REG_MODE, 32'(lspp_pkg::MODE_RAINBOW));
		write_reg(lspp_pkg::REG_SATURATION, 32'(pick_level()));
		write_reg(lspp_pkg::REG_LIGHTNESS, 32'(pick_level()));
		hold_cycles <= HOLD_CYCLES;
		repeat (40) send_pixel(random_time(), random_index());
		drain_pixels();
		send_idle_pct = saved_idle;
	endtask

	task automatic test_random(int n_items, int tx_idle, int rx_idle);
		int sent;
		int pick;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		sent = 0;
		while (sent < n_items) begin
			drain_pixels();
			pick = $urandom_range(9);
			write_reg(lspp_pkg::REG_MODE, ($urandom() & 32'hFFFF_FFFC) |
				32'((pick == 9) ? MODE_UNUSED : 2'(pick % 3)));
			write_reg(lspp_pkg::REG_SOLID, $urandom());
			write_reg(lspp_pkg::REG_SATURATION,
				($urandom() & 32'hFFFF_FF00) | 32'(pick_level()));
			write_reg(lspp_pkg::REG_LIGHTNESS,
				($urandom() & 32'hFFFF_FF00) | 32'(pick_level()));
			repeat (38) send_pixel(random_time(), random_index());
			sent += 38;
		end
		drain_pixels();
	endtask

	initial begin
		shadow_cfg.mode = lspp_pkg::RESET_MODE;
		shadow_cfg.solid = lspp_pkg::RESET_SOLID;
		shadow_cfg.sat = lspp_pkg::RESET_SATURATION;
		shadow_cfg.light = lspp_pkg::RESET_LIGHTNESS;
		send_idle_pct = 10;
		recv_idle_pct = 61;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_rainbow();
		test_channel_overflow();
		test_grey();
		test_solid();
		test_square();
		test_unused_mode();
		test_output_backpressure();
		test_random(380, 10, 61);
		test_random(380, 61, 10);
		test_random(380, 0, 0);

		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lspp_pkg.sv
hw/rtl/lspp_cfg_regs.sv
hw/rtl/lspp_chan.sv
hw/rtl/led_strip_pattern_pixel.sv
tb/sv/led_strip_pattern_pixel_tb.sv
